### design/wslm_pkg.sv
// Wheel speed limit monitor package: shared constants, register map,
// configuration struct and sequencer state type. No dependencies.

package wslm_pkg;

    localparam int SPEED_W   = 21;
    localparam int PULSE_W   = 20;
    localparam int IDLE_W    = 17;
    localparam int COUNT_W   = 8;
    localparam int SPACING_W = 12;
    localparam int TIMEOUT_W = 16;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    // mm per ms is m/s; 3.6 km/h per m/s in 0.01 km/h units
    localparam logic [SPEED_W-1:0] SPEED_FACTOR = SPEED_W'(360);
    localparam logic [SPEED_W-1:0] SPEED_MAX    = SPEED_W'(1474200);
    localparam logic [PULSE_W-1:0] PULSE_SAT    = {PULSE_W{1'b1}};
    localparam logic [IDLE_W-1:0]  IDLE_SAT     = {IDLE_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_SAT    = {COUNT_W{1'b1}};

    localparam logic [SPACING_W-1:0] SPACING_RST = SPACING_W'(1000);
    localparam logic [SPEED_W-1:0]   LIMIT_RST   = SPEED_W'(2400);
    localparam logic [COUNT_W-1:0]   PASSES_RST  = COUNT_W'(3);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(1000);

    typedef enum logic [1:0] {
        REG_SPACING = 2'd0,
        REG_LIMIT   = 2'd1,
        REG_PASSES  = 2'd2,
        REG_TIMEOUT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [SPACING_W-1:0] spacing;
        logic [SPEED_W-1:0]   limit;
        logic [COUNT_W-1:0]   passes;
        logic [TIMEOUT_W-1:0] timeout;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_FIN  = 2'd2
    } state_t;

endpackage

### design/wslm_regs.sv
// Configuration register file behind the APB-style port.
// Depends on wslm_pkg for the register map and cfg_t.

module wslm_regs
    import wslm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SPACING: cfg_next.spacing = pwdata[SPACING_W-1:0];
                REG_LIMIT:   cfg_next.limit   = pwdata[SPEED_W-1:0];
                REG_PASSES:  cfg_next.passes  = pwdata[COUNT_W-1:0];
                REG_TIMEOUT: cfg_next.timeout = pwdata[TIMEOUT_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SPACING: prdata = DATA_W'(cfg_reg.spacing);
            REG_LIMIT:   prdata = DATA_W'(cfg_reg.limit);
            REG_PASSES:  prdata = DATA_W'(cfg_reg.passes);
            REG_TIMEOUT: prdata = DATA_W'(cfg_reg.timeout);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spacing <= SPACING_RST;
            cfg_reg.limit   <= LIMIT_RST;
            cfg_reg.passes  <= PASSES_RST;
            cfg_reg.timeout <= TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/wslm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wslm_pkg for widths. Divisor must be nonzero.

module wslm_div
    import wslm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SPEED_W-1:0] dividend,
    input  logic [PULSE_W-1:0] divisor,
    output logic               done,
    output logic [SPEED_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SPEED_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SPEED_W - 1);

    logic [PULSE_W-1:0] rem_reg, rem_next;
    logic [SPEED_W-1:0] quo_reg, quo_next;
    logic [PULSE_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [PULSE_W:0]   trial;
    logic               fits;

    // shift next dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[SPEED_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_next = PULSE_W'(trial - {1'b0, den_reg});
            else
                rem_next = trial[PULSE_W-1:0];
            quo_next = {quo_reg[SPEED_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/wheel_speed_limit_monitor.sv
// Top level of the wheel speed limit monitor: tick sequencer, overspeed
// and stall logic. Uses wslm_pkg, wslm_regs and wslm_div.
//
//  channel | signals                                   | beat
//  --------+-------------------------------------------+-----------------------
//  in      | in_valid, in_ready, sensor_level          | one 1 ms sensor tick
//  out     | out_valid, out_ready, speed, drive_allowed| one result per tick
//  cfg     | psel, penable, pwrite, paddr, pwdata, ... | 32-bit register write
//
// A tick with no rising edge goes from idle straight to the finish step; a
// rising edge first runs the divider, one quotient bit per cycle (21 bits).
// in_ready is high only while the sequencer is idle. A finished result sits in
// the output register; a new tick is accepted meanwhile, and its finish step
// waits until that result is taken. Reset restores state and control registers.

module wheel_speed_limit_monitor
    import wslm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                sensor_level,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SPEED_W-1:0]  speed,
    output logic                drive_allowed,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    cfg_t cfg;

    state_t             state_reg, state_next;
    logic               prev_reg, prev_next;
    logic               rising_reg, rising_next;
    logic [PULSE_W-1:0] pulse_reg, pulse_next;
    logic [IDLE_W-1:0]  idle_reg, idle_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic [COUNT_W-1:0] ocount_reg, ocount_next;
    logic               allow_reg, allow_next;
    logic               out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0] out_speed_reg, out_speed_next;
    logic               out_allow_reg, out_allow_next;

    logic               falling, rising;
    logic               div_start, div_done;
    logic [SPEED_W-1:0] quotient;
    logic [SPEED_W-1:0] numerator;
    logic [SPEED_W-1:0] meas_speed;
    logic               slot_free;

    wslm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // spacing * 360 tops out at 1474200, fits the speed width
    assign numerator = SPEED_W'(SPEED_W'(cfg.spacing) * SPEED_FACTOR);

    wslm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (numerator),
        .divisor  (pulse_next),
        .done     (div_done),
        .quotient (quotient)
    );

    assign falling   = !sensor_level && prev_reg;
    assign rising    = sensor_level && !prev_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    assign meas_speed = (pulse_reg == '0) ? SPEED_MAX : quotient;

    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        rising_next    = rising_reg;
        pulse_next     = pulse_reg;
        idle_next      = idle_reg;
        speed_next     = speed_reg;
        ocount_next    = ocount_reg;
        allow_next     = allow_reg;
        out_speed_next = out_speed_reg;
        out_allow_next = out_allow_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    prev_next   = sensor_level;
                    rising_next = rising;
                    if (falling)
                        pulse_next = '0;
                    else if (pulse_reg != PULSE_SAT)
                        pulse_next = pulse_reg + PULSE_W'(1);
                    if (falling || rising)
                        idle_next = '0;
                    else if (idle_reg != IDLE_SAT)
                        idle_next = idle_reg + IDLE_W'(1);
                    if (rising && (pulse_next != '0))
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (slot_free)
                begin
                    if (rising_reg)
                    begin
                        speed_next = meas_speed;
                        if (meas_speed > cfg.limit)
                        begin
                            if (ocount_reg > cfg.passes)
                                allow_next = 1'b0;
                            else if (ocount_reg != COUNT_SAT)
                                ocount_next = ocount_reg + COUNT_W'(1);
                        end
                        else
                        begin
                            allow_next  = 1'b1;
                            ocount_next = '0;
                        end
                    end
                    // stall: no edge for longer than the timeout
                    if (idle_reg > IDLE_W'(cfg.timeout))
                    begin
                        speed_next = '0;
                        allow_next = 1'b1;
                    end
                    out_speed_next = speed_next;
                    out_allow_next = allow_next;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= 1'b1;
            rising_reg    <= 1'b0;
            pulse_reg     <= '0;
            idle_reg      <= '0;
            speed_reg     <= '0;
            ocount_reg    <= '0;
            allow_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            rising_reg    <= rising_next;
            pulse_reg     <= pulse_next;
            idle_reg      <= idle_next;
            speed_reg     <= speed_next;
            ocount_reg    <= ocount_next;
            allow_reg     <= allow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_speed_reg <= out_speed_next;
        out_allow_reg <= out_allow_next;
    end

    assign out_valid     = out_valid_reg;
    assign speed         = out_speed_reg;
    assign drive_allowed = out_allow_reg;

endmodule
